/* hdl/slcfr_pkg.sv */
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types, constants and the byte-wide CRC-16 update for the sync /
// length / payload / CRC frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

   // channel count and derived widths
   localparam int CHANNELS = 16;
   localparam int MASK_W   = 16;
   localparam int CHAN_W   = 4;
   localparam logic [7:0] CHANNELS_B = 8'(CHANNELS);

   // frame codes
   localparam logic [7:0] SYNC_BYTE     = 8'hA5;
   localparam logic [7:0] CMD_POWER_OFF = 8'd254;
   localparam logic [7:0] CMD_POWER_ON  = 8'd255;

   // reflected CRC-16 polynomial
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // frame phase
   typedef enum logic [2:0] {
      PH_SYNC   = 3'd0,
      PH_CMD    = 3'd1,
      PH_LEN    = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRC_HI = 3'd4,
      PH_CRC_LO = 3'd5
   } phase_type;

   // one result word
   typedef struct packed {
      logic              deliver;
      logic [CHAN_W-1:0] channel;
      logic [7:0]        payload;
      logic [MASK_W-1:0] power_off_mask;
      logic [MASK_W-1:0] pending_mask;
      logic              frame_end;
      logic              crc_ok;
   } rsp_word_type;

   // crc update over one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* hdl/slcfr_if.sv */
// ----------------------------------------------------------------------------
// slcfr request and response channels
// Valid / ready channels carrying received bytes in and result words out.
// ----------------------------------------------------------------------------
interface slcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        deliver;
   logic [3:0]  channel;
   logic [7:0]  payload;
   logic [15:0] power_off_mask;
   logic [15:0] pending_mask;
   logic        frame_end;
   logic        crc_ok;

   modport source (output valid, output deliver, output channel, output payload,
                   output power_off_mask, output pending_mask, output frame_end,
                   output crc_ok, input ready);
   modport sink (input valid, input deliver, input channel, input payload,
                 input power_off_mask, input pending_mask, input frame_end,
                 input crc_ok, output ready);
endinterface

/* hdl/slcfr_in_stage.sv */
// ----------------------------------------------------------------------------
// slcfr_in_stage
// Input register: captures one received byte and holds it until the
// parser moves it on.
// ----------------------------------------------------------------------------
module slcfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       in_ready,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);
   import slcfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // free when empty or when the held word moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // byte register, no reset needed
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

/* hdl/slcfr_parser.sv */
// ----------------------------------------------------------------------------
// slcfr_parser
// Frame state machine: sync hunt, command, length, payload, CRC bytes,
// running CRC and the per-channel power and pending bits.
// ----------------------------------------------------------------------------
module slcfr_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output slcfr_pkg::rsp_word_type word
);
   import slcfr_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        command_ff, command_in;
   logic [7:0]        remaining_ff, remaining_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        crc_hi_ff, crc_hi_in;
   logic [MASK_W-1:0] power_off_ff, power_off_in;
   logic [MASK_W-1:0] pending_ff, pending_in;

   logic [15:0]       crc_next;
   logic [7:0]        remaining_dec;
   logic [MASK_W-1:0] chan_bit;

   assign crc_next      = crc_byte(crc_ff, rx_byte);
   assign remaining_dec = remaining_ff - 8'd1;
   assign chan_bit      = MASK_W'(1) << rx_byte[CHAN_W-1:0];

   // next state and result word
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      remaining_in = remaining_ff;
      crc_in       = crc_ff;
      crc_hi_in    = crc_hi_ff;
      power_off_in = power_off_ff;
      pending_in   = pending_ff;
      word         = '0;

      unique case (phase_ff)
         PH_CMD: begin
            crc_in     = crc_next;
            command_in = rx_byte;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            crc_in       = crc_next;
            remaining_in = rx_byte;
            phase_in     = PH_DATA;
         end
         PH_DATA: begin
            crc_in = crc_next;
            if (command_ff < CHANNELS_B) begin
               word.deliver = 1'b1;
               word.channel = command_ff[CHAN_W-1:0];
               word.payload = rx_byte;
            end
            if ((command_ff == CMD_POWER_OFF || command_ff == CMD_POWER_ON)
                && rx_byte < CHANNELS_B) begin
               if (command_ff == CMD_POWER_OFF) begin
                  power_off_in = power_off_ff | chan_bit;
               end else begin
                  power_off_in = power_off_ff & ~chan_bit;
               end
               pending_in = pending_ff | chan_bit;
            end
            remaining_in = remaining_dec;
            if (remaining_dec == 8'd0) begin
               phase_in = PH_CRC_HI;
            end
         end
         PH_CRC_HI: begin
            crc_hi_in = rx_byte;
            phase_in  = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            word.frame_end = 1'b1;
            word.crc_ok    = ({crc_hi_ff, rx_byte} == crc_ff);
            phase_in       = PH_SYNC;
         end
         default: begin
            phase_in = (rx_byte == SYNC_BYTE) ? PH_CMD : PH_SYNC;
            crc_in   = '0;
         end
      endcase

      word.power_off_mask = power_off_in;
      word.pending_mask   = pending_in;
   end

   // state registers, updated once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC;
         command_ff   <= '0;
         remaining_ff <= '0;
         crc_ff       <= '0;
         crc_hi_ff    <= '0;
         power_off_ff <= '0;
         pending_ff   <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         remaining_ff <= remaining_in;
         crc_ff       <= crc_in;
         crc_hi_ff    <= crc_hi_in;
         power_off_ff <= power_off_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

/* hdl/slcfr_out_stage.sv */
// ----------------------------------------------------------------------------
// slcfr_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module slcfr_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  slcfr_pkg::rsp_word_type word,
   output logic                    free,
   output logic                    out_valid,
   input  logic                    out_ready,
   output slcfr_pkg::rsp_word_type out_word
);
   import slcfr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // room for a new word when empty or being drained
   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (free && load) begin
         word_ff <= word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* hdl/sync_length_crc_frame_receiver.sv */
// Path: a byte accepted into the input register goes through the parser into the result register once it has room.
// Throughput: one byte per cycle while the result register is not stalled; the frame state and CRC update in one pass.
// A stalled result register holds back one further byte in the input register.
// Reset (synchronous, active high) empties both registers, returns to sync
// hunt and clears the CRC, power-off and pending bits.
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver
// Top level: input register, frame parser and result register.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_receiver (
   input  logic         clock,
   input  logic         reset,
   slcfr_req_if.sink    req_if,
   slcfr_rsp_if.source  rsp_if
);
   import slcfr_pkg::*;

   logic         held_valid;
   logic [7:0]   held_byte;
   logic         free;
   logic         advance;
   rsp_word_type word;
   rsp_word_type out_word;

   // move a held byte on when the result register has room
   assign advance = held_valid && free;

   slcfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_byte    (req_if.rx_byte),
      .in_ready   (req_if.ready),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   slcfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (held_byte),
      .word    (word)
   );

   slcfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .word      (word),
      .free      (free),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_word  (out_word)
   );

   // result word onto the channel
   assign rsp_if.deliver        = out_word.deliver;
   assign rsp_if.channel        = out_word.channel;
   assign rsp_if.payload        = out_word.payload;
   assign rsp_if.power_off_mask = out_word.power_off_mask;
   assign rsp_if.pending_mask   = out_word.pending_mask;
   assign rsp_if.frame_end      = out_word.frame_end;
   assign rsp_if.crc_ok         = out_word.crc_ok;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync / length / CRC frame receiver. Received
// bytes go in as framed traffic (good, corrupted and truncated frames mixed
// with line noise). A scoreboard tracks the frame parser, the CRC and the
// power bits per input word, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import slcfr_pkg::*;

   typedef logic [7:0] byte_q_t[$];

   localparam int IDLE_LIMIT = 500;
   localparam int WORDS_TOTAL = 1280;

   // scoreboard: tracks the frame state and holds the expected result words
   class frame_scoreboard;
      phase_type    phase;
      logic [7:0]   command;
      logic [7:0]   remaining;
      logic [15:0]  crc_acc;
      logic [7:0]   crc_high;
      logic [15:0]  off_bits;
      logic [15:0]  pending;
      rsp_word_type expected_words[$];
      int           mismatches;

      function new();
         phase      = PH_SYNC;
         command    = '0;
         remaining  = '0;
         crc_acc    = '0;
         crc_high   = '0;
         off_bits   = '0;
         pending    = '0;
         mismatches = 0;
      endfunction

      // bit-serial reflected crc-16, lsb of the byte first
      static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb) begin
               crc = crc ^ CRC_POLY;
            end
         end
         return crc;
      endfunction

      function void note_rx_word(logic [7:0] b);
         rsp_word_type w;
         logic [15:0]  chan_bit;
         w = '0;
         case (phase)
            PH_CMD: begin
               crc_acc = crc16_update(crc_acc, b);
               command = b;
               phase   = PH_LEN;
            end
            PH_LEN: begin
               crc_acc   = crc16_update(crc_acc, b);
               remaining = b;
               phase     = PH_DATA;
            end
            PH_DATA: begin
               crc_acc = crc16_update(crc_acc, b);
               // channel commands deliver the byte
               if (command < CHANNELS_B) begin
                  w.deliver = 1'b1;
                  w.channel = command[CHAN_W-1:0];
                  w.payload = b;
               end
               // power commands act only on a byte that names a channel
               if ((command == CMD_POWER_OFF || command == CMD_POWER_ON) && b < CHANNELS_B) begin
                  chan_bit = 16'd1 << b[CHAN_W-1:0];
                  if (command == CMD_POWER_OFF) begin
                     off_bits = off_bits | chan_bit;
                  end else begin
                     off_bits = off_bits & ~chan_bit;
                  end
                  pending = pending | chan_bit;
               end
               // a length of zero wraps round to 256 bytes
               remaining = remaining - 8'd1;
               if (remaining == 8'd0) begin
                  phase = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               crc_high = b;
               phase    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               w.frame_end = 1'b1;
               w.crc_ok    = ({crc_high, b} == crc_acc);
               phase       = PH_SYNC;
            end
            default: begin
               phase   = (b == SYNC_BYTE) ? PH_CMD : PH_SYNC;
               crc_acc = '0;
            end
         endcase
         w.power_off_mask = off_bits;
         w.pending_mask   = pending;
         expected_words.push_back(w);
      endfunction

      function void field_check(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: result word expected none got %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         field_check("deliver", 16'(want.deliver), 16'(got.deliver));
         field_check("channel", 16'(want.channel), 16'(got.channel));
         field_check("payload", 16'(want.payload), 16'(got.payload));
         field_check("power_off_mask", want.power_off_mask, got.power_off_mask);
         field_check("pending_mask", want.pending_mask, got.pending_mask);
         field_check("frame_end", 16'(want.frame_end), 16'(got.frame_end));
         field_check("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
      endfunction
   endclass

   logic clock;
   logic reset;

   slcfr_req_if req_bus ();
   slcfr_rsp_if rsp_bus ();

   sync_length_crc_frame_receiver dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   frame_scoreboard sb;
   int words_in;
   int words_out;
   int src_run;
   bit src_quiet;
   int snk_run;
   bit snk_quiet;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // wait length per word; stretches of random waits alternate with bursts
   function automatic int draw_wait(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         quiet    = ($urandom_range(3, 0) == 0);
         run_left = $urandom_range(40, 10);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(12, 0);
   endfunction

   // one input word: optional gap, then hold valid until accepted
   task automatic send_rx_word(input logic [7:0] b);
      int gap;
      gap = draw_wait(src_run, src_quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_rx_word(b);
      words_in++;
   endtask

   // sync, command, length, payload and crc; cut >= 0 stops the payload early
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input bit corrupt, input int cut, input byte_q_t fixed);
      logic [15:0] crc;
      logic [7:0]  b;
      int          n;
      n   = (len == 8'd0) ? 256 : int'(len);
      crc = '0;
      send_rx_word(SYNC_BYTE);
      send_rx_word(cmd);
      crc = frame_scoreboard::crc16_update(crc, cmd);
      send_rx_word(len);
      crc = frame_scoreboard::crc16_update(crc, len);
      for (int i = 0; i < n; i++) begin
         if (i == cut) begin
            return;
         end
         if (i < fixed.size()) begin
            b = fixed[i];
         end else if (cmd == CMD_POWER_OFF || cmd == CMD_POWER_ON) begin
            // mostly valid channel numbers, now and then anything
            b = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0))
                                             : 8'($urandom_range(CHANNELS - 1, 0));
         end else begin
            b = 8'($urandom_range(255, 0));
         end
         send_rx_word(b);
         crc = frame_scoreboard::crc16_update(crc, b);
      end
      if (corrupt) begin
         crc = crc ^ (16'd1 << $urandom_range(15, 0));
      end
      send_rx_word(crc[15:8]);
      send_rx_word(crc[7:0]);
   endtask

   // result side: random stalls, check every accepted word
   initial begin
      rsp_word_type got;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int stall;
         stall = draw_wait(snk_run, snk_quiet);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         got.deliver        = rsp_bus.deliver;
         got.channel        = rsp_bus.channel;
         got.payload        = rsp_bus.payload;
         got.power_off_mask = rsp_bus.power_off_mask;
         got.pending_mask   = rsp_bus.pending_mask;
         got.frame_end      = rsp_bus.frame_end;
         got.crc_ok         = rsp_bus.crc_ok;
         sb.check_word(got);
         words_out++;
      end
   end

   // watchdog on cycles with no word moving on either side
   initial begin
      int idle;
      int seen_in;
      int seen_out;
      idle     = 0;
      seen_in  = 0;
      seen_out = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (words_in != seen_in || words_out != seen_out) begin
            idle = 0;
         end else begin
            idle++;
         end
         seen_in  = words_in;
         seen_out = words_out;
      end
      $display("tb_top: errors");
      $finish;
   end

   // stimulus
   initial begin
      byte_q_t     pay;
      logic [7:0]  cmd;
      logic [7:0]  len;
      int          kind;
      int          cut;
      int          n;
      sb                = new();
      words_in          = 0;
      words_out         = 0;
      src_run           = 0;
      snk_run           = 0;
      src_quiet         = 1'b0;
      snk_quiet         = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.rx_byte   = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // noise while hunting
      send_rx_word(8'h00);
      send_rx_word(8'hFF);
      // top channel, extreme payload, good crc
      pay = '{8'hFF};
      send_frame(8'(CHANNELS - 1), 8'd1, 1'b0, -1, pay);
      // power off: first and last channel, then a byte naming no channel
      pay = '{8'h00, 8'(CHANNELS - 1), 8'(CHANNELS)};
      send_frame(CMD_POWER_OFF, 8'd3, 1'b0, -1, pay);
      // power on with a broken crc
      pay = '{8'h00};
      send_frame(CMD_POWER_ON, 8'd1, 1'b1, -1, pay);
      // other command: payload dropped
      pay = '{8'h05};
      send_frame(8'd200, 8'd1, 1'b0, -1, pay);

      // length zero means 256 payload bytes
      pay.delete();
      send_frame(8'd0, 8'd0, 1'b0, -1, pay);

      // random traffic: mostly well-formed frames, some noise and cut frames
      while (words_in < WORDS_TOTAL) begin
         if ($urandom_range(99, 0) < 8) begin
            n = $urandom_range(4, 1);
            repeat (n) send_rx_word(8'($urandom_range(255, 0)));
         end else begin
            kind = $urandom_range(9, 0);
            if (kind < 5) begin
               cmd = 8'($urandom_range(CHANNELS - 1, 0));
            end else if (kind < 7) begin
               cmd = CMD_POWER_OFF;
            end else if (kind == 7) begin
               cmd = CMD_POWER_ON;
            end else if (kind == 8) begin
               cmd = 8'($urandom_range(253, CHANNELS));
            end else begin
               cmd = 8'($urandom_range(255, 0));
            end
            kind = $urandom_range(39, 0);
            if (kind == 0) begin
               len = 8'd0;
            end else if (kind == 1) begin
               len = 8'($urandom_range(255, 9));
            end else begin
               len = 8'($urandom_range(8, 1));
            end
            n   = (len == 8'd0) ? 256 : int'(len);
            cut = ($urandom_range(15, 0) == 0) ? $urandom_range(n - 1, 0) : -1;
            send_frame(cmd, len, ($urandom_range(7, 0) == 0), cut, pay);
         end
      end
      req_bus.valid <= 1'b0;

      // drain, then allow for the pipeline
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
